@@ src/drc_pkg.sv @@
// Shared constants and codes for the dense rank compressor.
package drc_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int AW        = $clog2(MAX_ITEMS);
	localparam int CW        = $clog2(MAX_ITEMS + 1);
	localparam int KEY_W     = 32;
	localparam int POS_W     = 10;
	localparam int RANK_W    = 10;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_LOADED = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

	typedef logic [CW-1:0] count_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [KEY_W-1:0] key_t;

endpackage

@@ src/drc_if.sv @@
// Request and response channels of the dense rank compressor.
interface drc_req_if;
	import drc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic signed [KEY_W-1:0] value;
	logic [POS_W-1:0]        position;

	modport source (output valid, command, value, position, input ready);
	modport sink   (input valid, command, value, position, output ready);
endinterface

interface drc_rsp_if;
	import drc_pkg::*;
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic [1:0]        status;

	modport source (output valid, rank, status, input ready);
	modport sink   (input valid, rank, status, output ready);
endinterface

@@ src/drc_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module drc_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/dense_rank_compressor_top.sv @@
// Dense rank compressor: sequencer around one shared key comparator and two RAMs.
// Takes one item at a time; ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next item is taken. Clear,
// a load into a full table and a query of an unloaded position go straight to the
// done state. A query does one arrival RAM read, then a binary search over the D
// distinct values held, each probe a read through the single registered read port of
// the sorted table and then a compare. A load takes the same search, one more read
// for the repeat check and, when the value is new, moves each entry at and above the
// insertion point up by one through the one read and one write port of the sorted RAM.
module dense_rank_compressor_top (
	input  logic       clk,
	input  logic       arst_n,
	drc_req_if.sink    req,
	drc_rsp_if.source  rsp
);
	import drc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_QWAIT, S_SRCH, S_SRCH_CMP, S_DUP_CMP, S_SHIFT, S_DONE
	} state_t;

	state_t            state_q;
	count_t            loaded_q, distinct_q;
	count_t            lo_q, hi_q, mid_q, r_q, wa_q;
	logic              pend_q, is_load_q;
	key_t              key_q;
	logic [RANK_W-1:0] res_rank_q;
	logic [1:0]        res_status_q;
	logic              out_v_q;
	logic [RANK_W-1:0] out_rank_q;
	logic [1:0]        out_status_q;

	logic              accept;
	key_t              in_key;
	logic [CW:0]       mid_sum;
	count_t            mid_w;
	logic              key_less;

	logic  arr_we;
	addr_t arr_raddr;
	key_t  arr_rdata;
	logic  sd_we;
	addr_t sd_waddr, sd_raddr;
	key_t  sd_wdata, sd_rdata;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign in_key     = $unsigned(req.value) ^ SIGN_FLIP;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w      = mid_sum[CW:1];
	// shared comparator: keys carry a flipped sign bit, so unsigned order is signed order
	assign key_less   = (sd_rdata < key_q);

	assign rsp.valid  = out_v_q;
	assign rsp.rank   = out_rank_q;
	assign rsp.status = out_status_q;

	assign arr_we    = accept && (req.command == CMD_LOAD) && (loaded_q < count_t'(MAX_ITEMS));
	assign arr_raddr = AW'(req.position);

	always_comb begin
		sd_raddr = lo_q[AW-1:0];
		sd_we    = 1'b0;
		sd_waddr = lo_q[AW-1:0];
		sd_wdata = key_q;
		if (state_q == S_SRCH && lo_q < hi_q) begin
			sd_raddr = mid_w[AW-1:0];
		end else if (state_q == S_SHIFT) begin
			sd_raddr = AW'(r_q - count_t'(1));
			if (pend_q) begin
				sd_we    = 1'b1;
				sd_waddr = wa_q[AW-1:0];
				sd_wdata = sd_rdata;
			end else if (!(r_q > lo_q)) begin
				sd_we = 1'b1;
			end
		end
	end

	drc_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_arrival (
		.clk   (clk),
		.we    (arr_we),
		.waddr (loaded_q[AW-1:0]),
		.wdata (in_key),
		.raddr (arr_raddr),
		.rdata (arr_rdata)
	);

	drc_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_sorted (
		.clk   (clk),
		.we    (sd_we),
		.waddr (sd_waddr),
		.wdata (sd_wdata),
		.raddr (sd_raddr),
		.rdata (sd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			loaded_q     <= '0;
			distinct_q   <= '0;
			out_v_q      <= 1'b0;
			out_rank_q   <= '0;
			out_status_q <= ST_OK;
			pend_q       <= 1'b0;
			is_load_q    <= 1'b0;
			key_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			r_q          <= '0;
			wa_q         <= '0;
			res_rank_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_rank_q   <= '0;
						res_status_q <= ST_OK;
						lo_q         <= '0;
						hi_q         <= distinct_q;
						key_q        <= in_key;
						state_q      <= S_DONE;
						case (req.command)
							CMD_CLEAR: begin
								loaded_q   <= '0;
								distinct_q <= '0;
							end
							CMD_LOAD: begin
								if (loaded_q >= count_t'(MAX_ITEMS)) begin
									res_status_q <= ST_FULL;
								end else begin
									loaded_q  <= loaded_q + count_t'(1);
									is_load_q <= 1'b1;
									state_q   <= S_SRCH;
								end
							end
							CMD_QUERY: begin
								if (32'(req.position) >= 32'(loaded_q)) begin
									res_status_q <= ST_NOT_LOADED;
								end else begin
									is_load_q <= 1'b0;
									state_q   <= S_QWAIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_QWAIT: begin
					key_q   <= arr_rdata;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w;
						state_q <= S_SRCH_CMP;
					end else if (!is_load_q) begin
						res_rank_q <= RANK_W'(lo_q);
						state_q    <= S_DONE;
					end else if (lo_q < distinct_q) begin
						state_q <= S_DUP_CMP;
					end else begin
						r_q     <= distinct_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SRCH_CMP: begin
					if (key_less) begin
						lo_q <= mid_q + count_t'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_DUP_CMP: begin
					if (sd_rdata == key_q) begin
						state_q <= S_DONE;
					end else begin
						r_q     <= distinct_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// read entry r-1 while writing the one read last cycle up by one
					if (r_q > lo_q) begin
						pend_q <= 1'b1;
						wa_q   <= r_q;
						r_q    <= r_q - count_t'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							distinct_q <= distinct_q + count_t'(1);
							state_q    <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q      <= 1'b1;
						out_rank_q   <= res_rank_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/dense_rank_compressor_top_tb.sv @@
// Self-checking testbench for the dense rank compressor: directed table, fill to full, random.
module dense_rank_compressor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 580;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [1:0]        status;
	} rank_result_t;

	typedef struct {
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] val;
		logic [POS_W-1:0]        pos;
		bit                      typed;
		rank_result_t            res;
	} directed_row_t;

	logic clk;
	logic arst_n;

	drc_req_if req_ch ();
	drc_rsp_if rsp_ch ();

	dense_rank_compressor_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the block's contents
	logic signed [KEY_W-1:0] shadow_arrivals [MAX_ITEMS];
	logic signed [KEY_W-1:0] shadow_distinct [$];
	int                      shadow_loaded = 0;

	rank_result_t  rank_results_due [$];
	directed_row_t directed_rows [$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  n_loads = 0, n_full = 0, n_queries = 0, n_unloaded = 0, n_clears = 0, n_unused = 0;
	int  sender_gap = 0, sender_quiet = 0, receiver_quiet = 0;
	bit  hold_output = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, rank_results_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	// Sorted table, so this is also the insertion index.
	function automatic int count_smaller(logic signed [KEY_W-1:0] v);
		int n = 0;
		foreach (shadow_distinct[i])
			if (shadow_distinct[i] < v)
				n++;
		return n;
	endfunction

	function automatic rank_result_t next_rank_result(logic [1:0] cmd,
			logic signed [KEY_W-1:0] val, logic [POS_W-1:0] pos);
		rank_result_t r;
		int at;
		r.rank = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_CLEAR: begin
				shadow_loaded = 0;
				shadow_distinct.delete();
			end
			CMD_LOAD: begin
				if (shadow_loaded >= MAX_ITEMS) begin
					r.status = ST_FULL;
				end else begin
					shadow_arrivals[shadow_loaded] = val;
					shadow_loaded++;
					at = count_smaller(val);
					if (at == shadow_distinct.size() || shadow_distinct[at] != val)
						shadow_distinct.insert(at, val);
				end
			end
			CMD_QUERY: begin
				if (int'(pos) >= shadow_loaded)
					r.status = ST_NOT_LOADED;
				else
					r.rank = RANK_W'(count_smaller(shadow_arrivals[pos]));
			end
			default: ;
		endcase
		return r;
	endfunction

	// Wait per item, with occasional stretches of back-to-back items.
	function automatic int pick_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			quiet_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic void add_row(logic [1:0] cmd, logic signed [KEY_W-1:0] val,
			logic [POS_W-1:0] pos, bit typed, logic [RANK_W-1:0] rank, logic [1:0] status);
		directed_row_t row;
		row.cmd = cmd;
		row.val = val;
		row.pos = pos;
		row.typed = typed;
		row.res.rank = rank;
		row.res.status = status;
		directed_rows = {directed_rows, row};
	endfunction

	task automatic offer_item(input logic [1:0] cmd, input logic signed [KEY_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit typed, input rank_result_t typed_res);
		rank_result_t r;
		if (sender_gap > 0)
			repeat (sender_gap) @(posedge clk);
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value <= val;
		req_ch.position <= pos;
		do @(posedge clk); while (!req_ch.ready);
		r = next_rank_result(cmd, val, pos);
		if (typed)
			r = typed_res;
		rank_results_due = {rank_results_due, r};
		case (cmd)
			CMD_CLEAR: n_clears++;
			CMD_LOAD: begin
				n_loads++;
				if (r.status == ST_FULL)
					n_full++;
			end
			CMD_QUERY: begin
				n_queries++;
				if (r.status == ST_NOT_LOADED)
					n_unloaded++;
			end
			default: n_unused++;
		endcase
		// valid drops now unless the next item follows straight on
		sender_gap = pick_wait(sender_quiet);
		if (sender_gap > 0)
			req_ch.valid <= 1'b0;
	endtask

	// Always advances to a clock edge before returning, so valid never gets two updates in a step.
	task automatic drain_results();
		if (sender_gap == 0)
			req_ch.valid <= 1'b0;
		sender_gap = 0;
		do @(posedge clk); while (rank_results_due.size() != 0);
	endtask

	// Result side
	initial begin
		int stall;
		rank_result_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_wait(receiver_quiet);
			if (hold_output) begin
				hold_output = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			results_seen++;
			if (rank_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got rank=%0d status=%0d",
					$time, rsp_ch.rank, rsp_ch.status);
				mismatches++;
			end else begin
				want = rank_results_due.pop_front();
				if (rsp_ch.rank !== want.rank) begin
					$display("%0t: rank mismatch, expected %0d, got %0d",
						$time, want.rank, rsp_ch.rank);
					mismatches++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, rsp_ch.status);
					mismatches++;
				end
			end
		end
	end

	// Request side
	initial begin
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] val;
		logic [POS_W-1:0]        pos;
		logic signed [KEY_W-1:0] fill_pool [6];
		rank_result_t            no_res;
		int                      pick;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		no_res = '0;

		// directed: empty set, extremes, repeats, boundaries, clear, unused command
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_NOT_LOADED);
		add_row(CMD_UNUSED, 32'shFFFF_FFFF, 10'd1023, 1'b1, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'sh8000_0000, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'sh7FFF_FFFF, 10'd1023, 1'b1, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'shFFFF_FFFF, 10'd0,    1'b0, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'sh0000_0001, 10'd0,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'shFFFF_FFFF, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd1,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd2,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd3,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd4,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd5,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd6,    1'b1, 10'd0, ST_NOT_LOADED);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd1023, 1'b1, 10'd0, ST_NOT_LOADED);
		add_row(CMD_LOAD,   32'sh8000_0000, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd6,    1'b1, 10'd0, ST_OK);
		add_row(CMD_CLEAR,  32'shFFFF_FFFF, 10'd1023, 1'b1, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_NOT_LOADED);
		add_row(CMD_LOAD,   32'sh5555_5555, 10'd0,    1'b0, 10'd0, ST_OK);
		add_row(CMD_LOAD,   32'shAAAA_AAAA, 10'd0,    1'b0, 10'd0, ST_OK);
		add_row(CMD_QUERY,  32'sh0000_0000, 10'd0,    1'b0, 10'd0, ST_OK);
		add_row(CMD_UNUSED, 32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_OK);
		add_row(CMD_CLEAR,  32'sh0000_0000, 10'd0,    1'b1, 10'd0, ST_OK);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_item(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].pos,
				directed_rows[i].typed, directed_rows[i].res);

		// sender stops until everything is back
		drain_results();

		// fill the arrival table from a handful of values, so inserts stay cheap
		fill_pool[0] = $urandom;
		fill_pool[1] = $urandom;
		fill_pool[2] = 32'sh8000_0000;
		fill_pool[3] = 32'sh7FFF_FFFF;
		fill_pool[4] = 32'sh0000_0000;
		fill_pool[5] = $urandom;
		offer_item(CMD_CLEAR, $urandom, POS_W'($urandom), 1'b0, no_res);
		while (shadow_loaded < MAX_ITEMS) begin
			if ($urandom_range(0, 63) == 0)
				offer_item(CMD_QUERY, $urandom, POS_W'($urandom_range(0, shadow_loaded)),
					1'b0, no_res);
			else
				offer_item(CMD_LOAD, fill_pool[$urandom_range(0, 5)], POS_W'($urandom),
					1'b0, no_res);
		end
		offer_item(CMD_LOAD, $urandom, POS_W'($urandom), 1'b0, no_res);
		offer_item(CMD_QUERY, $urandom, 10'd1023, 1'b0, no_res);
		offer_item(CMD_QUERY, $urandom, POS_W'($urandom_range(0, 1023)), 1'b0, no_res);
		offer_item(CMD_LOAD, 32'sh8000_0000, 10'd0, 1'b0, no_res);
		offer_item(CMD_UNUSED, $urandom, POS_W'($urandom), 1'b0, no_res);
		offer_item(CMD_CLEAR, $urandom, POS_W'($urandom), 1'b0, no_res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100) begin
				// output held off while inputs keep coming back to back
				hold_output = 1'b1;
				sender_quiet = 40;
			end
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			val = $urandom;
			pos = POS_W'($urandom);
			if (pick < 2)
				cmd = CMD_CLEAR;
			else if (pick < 4)
				cmd = CMD_UNUSED;
			else if (pick < 50 || shadow_loaded == 0)
				cmd = CMD_LOAD;
			else
				cmd = CMD_QUERY;
			if (cmd == CMD_LOAD) begin
				pick = $urandom_range(0, 9);
				if (pick < 4 && shadow_loaded > 0)
					val = shadow_arrivals[$urandom_range(0, shadow_loaded - 1)];
				else if (pick < 7)
					val = $urandom_range(0, 64) - 32;
			end else if (cmd == CMD_QUERY) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					pos = POS_W'(shadow_loaded);
				else if (pick < 8)
					pos = POS_W'($urandom_range(0, shadow_loaded - 1));
			end
			offer_item(cmd, val, pos, 1'b0, no_res);
		end

		drain_results();
		repeat (50) @(posedge clk);

		$display("Covered %0d loads (%0d into a full table), %0d queries (%0d unloaded),",
			n_loads, n_full, n_queries, n_unloaded);
		$display("  %0d clears, %0d unused commands; %0d results compared, %0d mismatches, %0d left",
			n_clears, n_unused, results_seen, mismatches, rank_results_due.size());
		if (mismatches == 0 && rank_results_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
